FILE: rtl/bmpd_pkg.sv
// Shared types and constants for the BMP stream pixel decoder.
package bmpd_pkg;

   // Largest accepted image dimension and the width of dimension fields
   localparam int MAX_DIM = 4096;
   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;

   // Header byte positions holding the last byte of each field
   localparam int POS_OFFSET_END = 13;
   localparam int POS_WIDTH_END  = 21;
   localparam int POS_HEIGHT_END = 25;
   localparam int POS_DEPTH_END  = 31;
   localparam int HEADER_BYTES   = 32;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXEL,
      PH_PAD,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_DEPTH,
      ERR_NEG_WIDTH,
      ERR_TOO_LARGE,
      ERR_OFFSET,
      ERR_TRUNCATED
   } err_type;

   typedef struct packed {
      logic               pixel_valid;
      logic [COORD_W-1:0] dest_row;
      logic [COORD_W-1:0] dest_col;
      logic [7:0]         chan_red;
      logic [7:0]         chan_green;
      logic [7:0]         chan_blue;
      logic [7:0]         chan_alpha;
      logic [2:0]         channel_count;
      logic [DIM_W-1:0]   pic_width;
      logic [DIM_W-1:0]   pic_height;
      err_type            error_code;
      logic               frame_done;
   } rsp_type;

endpackage

FILE: rtl/bmpd_parser.sv
// Header parser, pixel assembler and row/column tracking for one byte per cycle when accepted.
module bmpd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_accept,
   input  logic [7:0]       file_byte,
   input  logic             end_of_file,
   output logic             res_valid,
   output bmpd_pkg::rsp_type res_data
);
   import bmpd_pkg::*;

   logic [31:0]      pos_ff, pos_in;
   logic [31:0]      hdr_shift_ff, hdr_shift_in;
   logic [31:0]      offset_ff, offset_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             top_first_ff, top_first_in;
   logic [2:0]       bpp_ff, bpp_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [1:0]       bip_ff, bip_in;
   logic [23:0]      pix_ff, pix_in;
   logic [1:0]       pad_ff, pad_in;
   phase_type        phase_ff, phase_in;

   logic [31:0]      shift;
   logic [31:0]      mag;
   logic [28:0]      chan;
   logic             do_pixel;
   logic [DIM_W-1:0] row_dest;
   logic [DIM_W-1:0] col_next;
   logic [DIM_W-1:0] row_next;
   logic [1:0]       pad_amt;

   // Next state and result for the accepted byte
   always_comb begin
      pos_in       = pos_ff;
      hdr_shift_in = hdr_shift_ff;
      offset_in    = offset_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      top_first_in = top_first_ff;
      bpp_in       = bpp_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      bip_in       = bip_ff;
      pix_in       = pix_ff;
      pad_in       = pad_ff;
      phase_in     = phase_ff;
      res_data     = '0;
      res_valid    = 1'b0;
      do_pixel     = 1'b0;
      shift        = {file_byte, hdr_shift_ff[31:8]};
      mag          = shift[31] ? (~shift + 32'd1) : shift;
      chan         = shift[31] ? 29'd0 : shift[31:3];
      row_dest     = top_first_ff ? row_ff : (height_ff - DIM_W'(1) - row_ff);
      col_next     = col_ff + DIM_W'(1);
      row_next     = row_ff + DIM_W'(1);
      pad_amt      = 2'd0 - 2'(width_ff[1:0] * bpp_ff[1:0]);

      if (byte_accept) begin
         case (phase_ff)
            PH_HEADER: begin
               hdr_shift_in = shift;
               pos_in       = pos_ff + 32'd1;
               // Check each field on its last byte
               if (pos_ff[4:0] == 5'(POS_OFFSET_END)) begin
                  offset_in = shift;
                  if (shift < 32'(HEADER_BYTES)) begin
                     res_data.error_code = ERR_OFFSET;
                     res_data.frame_done = 1'b1;
                     res_valid           = 1'b1;
                     phase_in            = PH_ERROR;
                  end
               end else if (pos_ff[4:0] == 5'(POS_WIDTH_END)) begin
                  if (shift[31]) begin
                     res_data.error_code = ERR_NEG_WIDTH;
                     res_data.frame_done = 1'b1;
                     res_valid           = 1'b1;
                     phase_in            = PH_ERROR;
                  end else if (shift > 32'(MAX_DIM)) begin
                     res_data.error_code = ERR_TOO_LARGE;
                     res_data.frame_done = 1'b1;
                     res_valid           = 1'b1;
                     phase_in            = PH_ERROR;
                  end else begin
                     width_in = shift[DIM_W-1:0];
                  end
               end else if (pos_ff[4:0] == 5'(POS_HEIGHT_END)) begin
                  if (mag > 32'(MAX_DIM)) begin
                     res_data.error_code = ERR_TOO_LARGE;
                     res_data.frame_done = 1'b1;
                     res_valid           = 1'b1;
                     phase_in            = PH_ERROR;
                  end else begin
                     height_in    = mag[DIM_W-1:0];
                     top_first_in = shift[31];
                  end
               end else if (pos_ff[4:0] == 5'(POS_DEPTH_END)) begin
                  if (chan != 29'd1 && chan != 29'd3 && chan != 29'd4) begin
                     res_data.error_code = ERR_DEPTH;
                     res_data.frame_done = 1'b1;
                     res_valid           = 1'b1;
                     phase_in            = PH_ERROR;
                  end else begin
                     bpp_in = chan[2:0];
                     if (width_ff == '0 || height_ff == '0) begin
                        // Empty image: report done and ignore the rest
                        phase_in            = PH_DONE;
                        res_data.frame_done = 1'b1;
                        res_valid           = 1'b1;
                     end else if (offset_ff == 32'(HEADER_BYTES)) begin
                        phase_in = PH_PIXEL;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
            end
            PH_SKIP: begin
               if (pos_ff >= offset_ff) begin
                  phase_in = PH_PIXEL;
                  do_pixel = 1'b1;
               end
               pos_in = pos_ff + 32'd1;
            end
            PH_PIXEL: begin
               do_pixel = 1'b1;
            end
            PH_PAD: begin
               pad_in = pad_ff - 2'd1;
               if (pad_ff == 2'd1) begin
                  phase_in = PH_PIXEL;
               end
            end
            default: begin
            end
         endcase

         // Collect pixel bytes, emit on the last one
         if (do_pixel) begin
            if ({1'b0, bip_ff} + 3'd1 < bpp_ff) begin
               pix_in = pix_ff | (24'(file_byte) << {bip_ff, 3'b000});
               bip_in = bip_ff + 2'd1;
            end else begin
               res_valid            = 1'b1;
               res_data.pixel_valid = 1'b1;
               res_data.dest_row    = row_dest[COORD_W-1:0];
               res_data.dest_col    = col_ff[COORD_W-1:0];
               if (bpp_ff == 3'd1) begin
                  res_data.chan_red = file_byte;
               end else begin
                  res_data.chan_red   = (bip_ff == 2'd2) ? file_byte : pix_ff[23:16];
                  res_data.chan_green = pix_ff[15:8];
                  res_data.chan_blue  = pix_ff[7:0];
                  if (bpp_ff == 3'd4) begin
                     res_data.chan_alpha = file_byte;
                  end
               end
               bip_in = 2'd0;
               pix_in = '0;
               if (col_next >= width_ff) begin
                  col_in = '0;
                  row_in = row_next;
                  if (row_next >= height_ff) begin
                     phase_in            = PH_DONE;
                     res_data.frame_done = 1'b1;
                  end else if (pad_amt != 2'd0) begin
                     pad_in   = pad_amt;
                     phase_in = PH_PAD;
                  end
               end else begin
                  col_in = col_next;
               end
            end
         end

         // Flag a file that ends before the image is complete
         if (end_of_file && (phase_in == PH_HEADER || phase_in == PH_SKIP ||
                             phase_in == PH_PIXEL || phase_in == PH_PAD)) begin
            res_data.error_code = ERR_TRUNCATED;
            res_data.frame_done = 1'b1;
            res_valid           = 1'b1;
         end

         res_data.channel_count = bpp_in;
         res_data.pic_width     = width_in;
         res_data.pic_height    = height_in;

         // Rearm for the next file
         if (end_of_file) begin
            pos_in       = '0;
            hdr_shift_in = '0;
            offset_in    = '0;
            width_in     = '0;
            height_in    = '0;
            top_first_in = 1'b0;
            bpp_in       = '0;
            row_in       = '0;
            col_in       = '0;
            bip_in       = '0;
            pix_in       = '0;
            pad_in       = '0;
            phase_in     = PH_HEADER;
         end
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hdr_shift_ff <= '0;
         offset_ff    <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         top_first_ff <= 1'b0;
         bpp_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         bip_ff       <= '0;
         pix_ff       <= '0;
         pad_ff       <= '0;
         phase_ff     <= PH_HEADER;
      end else begin
         pos_ff       <= pos_in;
         hdr_shift_ff <= hdr_shift_in;
         offset_ff    <= offset_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         top_first_ff <= top_first_in;
         bpp_ff       <= bpp_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         bip_ff       <= bip_in;
         pix_ff       <= pix_in;
         pad_ff       <= pad_in;
         phase_ff     <= phase_in;
      end
   end

endmodule

FILE: rtl/bmpd_out_skid.sv
// Result register with a skid entry so the input side never waits on a stall directly.
module bmpd_out_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  bmpd_pkg::rsp_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output bmpd_pkg::rsp_type out_data,
   input  logic              out_ready
);
   import bmpd_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;

   // Refill the result register from the skid entry first, then from the parser
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = in_valid;
         end
      end else if (in_valid) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

FILE: rtl/bmp_stream_pixel_decoder.sv
// Top level of the BMP stream pixel decoder: byte stream in, decoded pixels out.
//
//  channel  dir  signals                      content
//  req      in   tvalid tready tdata tlast    one file byte, tlast marks end of file
//  rsp      out  tvalid tready tdata tuser    one pixel, empty-image or error report
//                tlast                        tlast marks last pixel, empty image or error
//
// One byte is taken per cycle while req_tready is high; its result, if any, is registered
// in the result register, or in the skid entry behind it during a stall. The skid entry
// lets the request side keep going during a stall until a second result is waiting;
// req_tready falls only while the skid entry is full.
// Synchronous reset returns the parser to the header phase and empties the output.
module bmp_stream_pixel_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] file_byte
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [11:0] dest_row, [23:12] dest_col, [31:24] chan_red,
                                    // [39:32] chan_green, [47:40] chan_blue,
                                    // [55:48] chan_alpha, [58:56] channel_count,
                                    // [71:59] pic_width, [84:72] pic_height, rest 0
   output logic [3:0]  rsp_tuser,   // [0] pixel_valid, [3:1] error_code
   output logic        rsp_tlast    // frame_done
);
   import bmpd_pkg::*;

   logic    byte_accept;
   logic    res_valid;
   rsp_type res_data;
   rsp_type out_data;

   assign byte_accept = req_tvalid && req_tready;

   bmpd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .file_byte   (req_tdata),
      .end_of_file (req_tlast),
      .res_valid   (res_valid),
      .res_data    (res_data)
   );

   bmpd_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .out_ready (rsp_tready)
   );

   // Pack the result fields onto the stream
   assign rsp_tdata = {3'b000, out_data.pic_height, out_data.pic_width,
                       out_data.channel_count, out_data.chan_alpha, out_data.chan_blue,
                       out_data.chan_green, out_data.chan_red, out_data.dest_col,
                       out_data.dest_row};
   assign rsp_tuser = {out_data.error_code, out_data.pixel_valid};
   assign rsp_tlast = out_data.frame_done;

endmodule

FILE: dv/bmp_stream_pixel_decoder_test.sv
// Self-checking testbench for the BMP stream pixel decoder: BMP byte streams in, pixels checked.
module bmp_stream_pixel_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bmpd_pkg::*;

   // One request: a file byte and its end-of-file mark
   typedef struct {
      logic [7:0] data;
      logic       last;
   } file_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;  // [7:0] file_byte
   logic        req_tlast = 1'b0;   // end_of_file
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;          // [11:0] dest_row, [23:12] dest_col, [31:24] chan_red,
                                    // [39:32] chan_green, [47:40] chan_blue,
                                    // [55:48] chan_alpha, [58:56] channel_count,
                                    // [71:59] pic_width, [84:72] pic_height
   logic [3:0]  rsp_tuser;          // [0] pixel_valid, [3:1] error_code
   logic        rsp_tlast;          // frame_done

   bmp_stream_pixel_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   file_byte_type file_stream[$];
   rsp_type       expected_reports[$];

   int fail_count    = 0;
   int files_queued  = 0;
   int bytes_queued  = 0;
   int bytes_taken   = 0;
   int pixels_seen   = 0;
   int reports_seen  = 0;
   int req_hold      = 0;
   int rsp_hold      = 0;
   int req_gap       = 0;
   int rsp_gap       = 0;
   bit req_burst     = 1'b0;
   bit rsp_burst     = 1'b0;
   rsp_type predicted;
   rsp_type observed;
   rsp_type wanted;
   string   bad_fields;

   // Parser state of the decoder as the testbench sees it
   int unsigned byte_pos, hdr_shift, data_offset, hold_w, hold_h, hold_bpp;
   int unsigned row_idx, col_idx, byte_idx, pix_acc, pad_left;
   logic        top_first;
   phase_type   parse_state;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Return the parser to the start of a file
   function automatic void rearm_parser();
      byte_pos    = 0;
      hdr_shift   = 0;
      data_offset = 0;
      hold_w      = 0;
      hold_h      = 0;
      hold_bpp    = 0;
      row_idx     = 0;
      col_idx     = 0;
      byte_idx    = 0;
      pix_acc     = 0;
      pad_left    = 0;
      top_first   = 1'b0;
      parse_state = PH_HEADER;
   endfunction

   function automatic void flag_error(input err_type code, inout rsp_type r, inout bit have);
      r.error_code = code;
      r.frame_done = 1'b1;
      have         = 1'b1;
      parse_state  = PH_ERROR;
   endfunction

   // Collect one pixel byte; emit the pixel once its last byte is in
   function automatic void take_pixel_byte(input logic [7:0] b, inout rsp_type r,
                                           inout bit have);
      int unsigned row, pad;
      if (byte_idx + 1 < hold_bpp) begin
         pix_acc  = (pix_acc | (32'(b) << (8 * (byte_idx & 3)))) & 32'h00FF_FFFF;
         byte_idx = (byte_idx + 1) & 3;
         return;
      end
      row = top_first ? row_idx : hold_h - 1 - row_idx;
      r.pixel_valid = 1'b1;
      r.dest_row    = row[11:0];
      r.dest_col    = col_idx[11:0];
      if (hold_bpp == 1) begin
         r.chan_red = b;
      end else begin
         // stored order is blue, green, red, alpha
         r.chan_red   = (byte_idx == 2) ? b : pix_acc[23:16];
         r.chan_green = pix_acc[15:8];
         r.chan_blue  = pix_acc[7:0];
         if (hold_bpp == 4) r.chan_alpha = b;
      end
      have     = 1'b1;
      byte_idx = 0;
      pix_acc  = 0;
      col_idx++;
      if (col_idx >= hold_w) begin
         col_idx = 0;
         row_idx++;
         if (row_idx >= hold_h) begin
            parse_state = PH_DONE;
            r.frame_done = 1'b1;
            return;
         end
         pad = (4 - ((hold_w * hold_bpp) & 3)) & 3;
         if (pad != 0) begin
            pad_left    = pad;
            parse_state = PH_PAD;
         end
      end
   endfunction

   // Work out the report, if any, that one file byte causes
   function automatic bit decode_file_byte(input logic [7:0] b, input logic eof,
                                           output rsp_type r);
      bit          have;
      int unsigned v, mag, ch;
      r    = '0;
      have = 1'b0;
      case (parse_state)
         PH_HEADER: begin
            hdr_shift = (hdr_shift >> 8) | {b, 24'h0};
            v = hdr_shift;
            if (byte_pos == POS_OFFSET_END) begin
               data_offset = v;
               if (v < HEADER_BYTES) flag_error(ERR_OFFSET, r, have);
            end else if (byte_pos == POS_WIDTH_END) begin
               if (v[31]) flag_error(ERR_NEG_WIDTH, r, have);
               else if (v > MAX_DIM) flag_error(ERR_TOO_LARGE, r, have);
               else hold_w = v;
            end else if (byte_pos == POS_HEIGHT_END) begin
               // negative height marks rows stored top first
               mag = v[31] ? ~v + 1 : v;
               if (mag > MAX_DIM) begin
                  flag_error(ERR_TOO_LARGE, r, have);
               end else begin
                  hold_h    = mag;
                  top_first = v[31];
               end
            end else if (byte_pos == POS_DEPTH_END) begin
               ch = v[31] ? 0 : v >> 3;
               if (ch != 1 && ch != 3 && ch != 4) begin
                  flag_error(ERR_DEPTH, r, have);
               end else begin
                  hold_bpp = ch;
                  if (hold_w == 0 || hold_h == 0) begin
                     parse_state  = PH_DONE;
                     r.frame_done = 1'b1;
                     have         = 1'b1;
                  end else begin
                     parse_state = (data_offset == HEADER_BYTES) ? PH_PIXEL : PH_SKIP;
                  end
               end
            end
            byte_pos++;
         end
         PH_SKIP: begin
            if (byte_pos >= data_offset) begin
               parse_state = PH_PIXEL;
               take_pixel_byte(b, r, have);
            end
            byte_pos++;
         end
         PH_PIXEL: take_pixel_byte(b, r, have);
         PH_PAD: begin
            pad_left = (pad_left - 1) & 3;
            if (pad_left == 0) parse_state = PH_PIXEL;
         end
         default: ;
      endcase
      // file ended before the image was complete
      if (eof && parse_state <= PH_PAD) begin
         r.error_code = ERR_TRUNCATED;
         r.frame_done = 1'b1;
         have         = 1'b1;
      end
      r.channel_count = hold_bpp[2:0];
      r.pic_width     = hold_w[12:0];
      r.pic_height    = hold_h[12:0];
      if (eof) rearm_parser();
      return have;
   endfunction

   function automatic string describe(input rsp_type r);
      return $sformatf({"valid=%0d row=%0d col=%0d rgba=%02h%02h%02h%02h chans=%0d ",
                        "w=%0d h=%0d err=%0d done=%0d"},
                       r.pixel_valid, r.dest_row, r.dest_col, r.chan_red, r.chan_green,
                       r.chan_blue, r.chan_alpha, r.channel_count, r.pic_width,
                       r.pic_height, r.error_code, r.frame_done);
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   // Bytes needed to reach the end of the last row of a well-formed image
   function automatic int image_span(input int off, input int w, input int h, input int bpp);
      return off - HEADER_BYTES + h * ((w * bpp + 3) & ~3);
   endfunction

   // Queue one file: header fields at their offsets, random bytes elsewhere, cut at total
   task automatic push_file(input logic [31:0] off, input logic [31:0] wf,
                            input logic [31:0] hf, input logic [31:0] df, input int total);
      file_byte_type fb;
      for (int i = 0; i < total; i++) begin
         fb.data = 8'($urandom_range(0, 255));
         if (i >= 10 && i <= 13) fb.data = off[8*(i-10) +: 8];
         if (i >= 18 && i <= 21) fb.data = wf[8*(i-18) +: 8];
         if (i >= 22 && i <= 25) fb.data = hf[8*(i-22) +: 8];
         if (i >= 28 && i <= 31) fb.data = df[8*(i-28) +: 8];
         fb.last = (i == total - 1);
         file_stream.insert(file_stream.size(), fb);
      end
      files_queued++;
      bytes_queued += total;
   endtask

   // Mostly well-formed small files, some cut short, some with bad or random headers
   task automatic random_file();
      int w, h, bpp, off, full, kind, total;
      logic [31:0] of, wf, hf, df;
      w    = $urandom_range(1, 6);
      h    = $urandom_range(1, 4);
      case ($urandom_range(0, 2))
         0:       bpp = 1;
         1:       bpp = 3;
         default: bpp = 4;
      endcase
      off  = HEADER_BYTES + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
      full = image_span(off, w, h, bpp);
      of   = off;
      wf   = w;
      hf   = $urandom_range(0, 1) ? -32'(h) : 32'(h);
      df   = bpp * 8 + $urandom_range(0, 7);
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
         total = HEADER_BYTES + full + $urandom_range(0, 3);
      end else if (kind < 17) begin
         total = $urandom_range(1, HEADER_BYTES + full - 1);
      end else if (kind < 19) begin
         // spoil one header field
         case ($urandom_range(0, 5))
            0:       of = $urandom_range(0, HEADER_BYTES - 1);
            1:       wf = $urandom | 32'h8000_0000;
            2:       wf = MAX_DIM + $urandom_range(1, 100);
            3:       hf = $urandom_range(0, 1) ? 32'(MAX_DIM + 1) : -32'(MAX_DIM + 1);
            4:       df = $urandom;
            default: if ($urandom_range(0, 1)) wf = 0; else hf = 0;
         endcase
         total = HEADER_BYTES + $urandom_range(0, 6);
      end else begin
         of    = $urandom;
         wf    = $urandom;
         hf    = $urandom;
         df    = $urandom;
         total = HEADER_BYTES + $urandom_range(0, 8);
      end
      push_file(of, wf, hf, df, total);
   endtask

   // Request driver: present queued bytes with random gaps, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_hold   <= 0;
      end else if (req_tvalid && req_tready) begin
         bytes_taken++;
         if (decode_file_byte(req_tdata, req_tlast, predicted))
            expected_reports.insert(expected_reports.size(), predicted);
         req_gap = req_burst ? 0 : $urandom_range(0, 10);
         if ($urandom_range(0, 63) == 0) req_burst = !req_burst;
         if (req_gap == 0 && file_stream.size() > 0) begin
            req_tdata  <= file_stream[0].data;
            req_tlast  <= file_stream[0].last;
            void'(file_stream.pop_front());
         end else begin
            req_tvalid <= 1'b0;
            req_hold   <= req_gap;
         end
      end else if (!req_tvalid) begin
         if (req_hold > 0) begin
            req_hold <= req_hold - 1;
         end else if (file_stream.size() > 0) begin
            req_tdata  <= file_stream[0].data;
            req_tlast  <= file_stream[0].last;
            req_tvalid <= 1'b1;
            void'(file_stream.pop_front());
         end
      end
   end

   // Report monitor: stall at random, compare each report with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tready && rsp_tvalid) begin
         observed.pixel_valid   = rsp_tuser[0];
         observed.error_code    = err_type'(rsp_tuser[3:1]);
         observed.frame_done    = rsp_tlast;
         observed.dest_row      = rsp_tdata[11:0];
         observed.dest_col      = rsp_tdata[23:12];
         observed.chan_red      = rsp_tdata[31:24];
         observed.chan_green    = rsp_tdata[39:32];
         observed.chan_blue     = rsp_tdata[47:40];
         observed.chan_alpha    = rsp_tdata[55:48];
         observed.channel_count = rsp_tdata[58:56];
         observed.pic_width     = rsp_tdata[71:59];
         observed.pic_height    = rsp_tdata[84:72];
         if (observed.pixel_valid === 1'b1) pixels_seen++;
         else reports_seen++;
         if (expected_reports.size() == 0) begin
            note_failure({"report with nothing expected: ", describe(observed)});
         end else begin
            wanted = expected_reports.pop_front();
            bad_fields = "";
            if (observed.pixel_valid !== wanted.pixel_valid)
               bad_fields = {bad_fields, " pixel_valid"};
            if (observed.dest_row !== wanted.dest_row) bad_fields = {bad_fields, " dest_row"};
            if (observed.dest_col !== wanted.dest_col) bad_fields = {bad_fields, " dest_col"};
            if (observed.chan_red !== wanted.chan_red) bad_fields = {bad_fields, " chan_red"};
            if (observed.chan_green !== wanted.chan_green)
               bad_fields = {bad_fields, " chan_green"};
            if (observed.chan_blue !== wanted.chan_blue) bad_fields = {bad_fields, " chan_blue"};
            if (observed.chan_alpha !== wanted.chan_alpha)
               bad_fields = {bad_fields, " chan_alpha"};
            if (observed.channel_count !== wanted.channel_count)
               bad_fields = {bad_fields, " channel_count"};
            if (observed.pic_width !== wanted.pic_width)
               bad_fields = {bad_fields, " pic_width"};
            if (observed.pic_height !== wanted.pic_height)
               bad_fields = {bad_fields, " pic_height"};
            if (observed.error_code !== wanted.error_code)
               bad_fields = {bad_fields, " error_code"};
            if (observed.frame_done !== wanted.frame_done)
               bad_fields = {bad_fields, " frame_done"};
            if (bad_fields != "")
               note_failure({"wrong", bad_fields, "\n   expected ", describe(wanted),
                             "\n   actual   ", describe(observed)});
         end
         rsp_gap = rsp_burst ? 0 : $urandom_range(0, 10);
         if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
         if (rsp_gap != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= rsp_gap;
         end
      end else if (!rsp_tready) begin
         if (rsp_hold > 0) rsp_hold <= rsp_hold - 1;
         else rsp_tready <= 1'b1;
      end
   end

   // Stimulus, reset and end of run
   initial begin
      rearm_parser();

      // well-formed files: padded rows, rows stored top first, grey, long skip
      push_file(32, 2, 2, 24, HEADER_BYTES + image_span(32, 2, 2, 3));
      push_file(36, 3, -32'd2, 32, HEADER_BYTES + image_span(36, 3, 2, 4) + 2);
      push_file(32, 5, 3, 8, HEADER_BYTES + image_span(32, 5, 3, 1));
      push_file(256, 1, 1, 8, HEADER_BYTES + image_span(256, 1, 1, 1));
      // header errors, the first found wins
      push_file(31, 2, 2, 24, 40);
      push_file(20, 32'hFFFF_FFFF, 2, 24, 40);
      push_file(32, 32'hFFFF_FFFF, 2, 24, 40);
      push_file(32, MAX_DIM + 1, 2, 24, 40);
      push_file(32, 2, MAX_DIM + 1, 24, 40);
      push_file(32, 2, -32'(MAX_DIM + 1), 24, 40);
      push_file(32, 2, 2, 16, 40);
      push_file(32, 2, 2, -32'd8, 40);
      push_file(32, 2, 2, 0, 34);
      // empty images
      push_file(32, 0, 3, 24, 40);
      push_file(32, 3, 0, 8, 40);
      // largest dimensions, cut short
      push_file(32, MAX_DIM, MAX_DIM, 8, HEADER_BYTES + 10);
      push_file(32, MAX_DIM, -32'(MAX_DIM), 32, HEADER_BYTES + 9);
      // truncation: on a completing byte, in the header, in the skip, one byte alone
      push_file(32, 2, 2, 24, HEADER_BYTES + 3);
      push_file(32, 2, 2, 24, 20);
      push_file(32'hFFFF_FFFF, 1, 1, 8, 40);
      push_file(0, 0, 0, 0, 1);

      while (bytes_queued < 1450) random_file();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // drain requests, then reports
      while (file_stream.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_reports.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Checked %0d files (%0d bytes): %0d pixels and %0d status reports.",
               files_queued, bytes_taken, pixels_seen, reports_seen);
      $display("Failures: %0d", fail_count);
      if (fail_count == 0) begin
         $display("bmp_stream_pixel_decoder: match");
      end else begin
         $display("bmp_stream_pixel_decoder: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Timeout with %0d reports outstanding", expected_reports.size());
      $display("bmp_stream_pixel_decoder: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
rtl/bmpd_pkg.sv
rtl/bmpd_parser.sv
rtl/bmpd_out_skid.sv
rtl/bmp_stream_pixel_decoder.sv
dv/bmp_stream_pixel_decoder_test.sv
